/* src/plc_pkg.sv */
`default_nettype none

package plc_pkg;

	// defaults for the top level parameters
	localparam int CAPACITY_DEF   = 64;
	localparam int ITEM_WIDTH_DEF = 32;

	// fixed width of the item fields on the ports
	localparam int PORT_ITEM_W = 32;

	// request codes
	localparam logic [1:0] OP_APPEND = 2'd0;
	localparam logic [1:0] OP_INSERT = 2'd1;
	localparam logic [1:0] OP_REMOVE = 2'd2;
	localparam logic [1:0] OP_READ   = 2'd3;

	// control broadcast to every cell of the row, already qualified by success
	typedef struct packed {
		logic ins;
		logic rem;
		logic rd;
	} cell_ctrl_t;

endpackage

`default_nettype wire

/* src/plc_cell.sv */
`default_nettype none

module plc_cell #(
	parameter int ITEM_WIDTH = 32,
	parameter int LEN_W      = 7,
	parameter int IDX        = 0
) (
	input  wire logic                   clk,
	input  wire plc_pkg::cell_ctrl_t    ctrl,
	input  wire logic [LEN_W-1:0]       at,
	input  wire logic [ITEM_WIDTH-1:0]  new_item,
	input  wire logic [ITEM_WIDTH-1:0]  left_item,
	input  wire logic [ITEM_WIDTH-1:0]  right_item,
	output logic      [ITEM_WIDTH-1:0]  item,
	output logic      [ITEM_WIDTH-1:0]  rd_item
);
	import plc_pkg::*;

	localparam logic [LEN_W-1:0] MY_IDX = LEN_W'(IDX);

	logic [ITEM_WIDTH-1:0] item_q;
	logic                  hit;
	logic                  above;

	// where this cell stands against the request position
	assign hit   = (at == MY_IDX);
	assign above = (MY_IDX > at);

	// shift up on insert, shift down on remove, load the new word at the gap
	always_ff @(posedge clk) begin
		if (ctrl.ins && above) begin
			item_q <= left_item;
		end else if (ctrl.ins && hit) begin
			item_q <= new_item;
		end else if (ctrl.rem && (above || hit)) begin
			item_q <= right_item;
		end
	end

	// own word towards the gather tree only when addressed by a read
	assign rd_item = (ctrl.rd && hit) ? item_q : '0;
	assign item    = item_q;

endmodule

`default_nettype wire

/* src/positional_list_engine_unit.sv */
`default_nettype none

// channel | direction | handshake           | payload
// in      | input     | in_valid / in_stall | opcode, position, item_in
// out     | output    | out_valid/out_stall | ok, item_out, length, empty_res
//
// A result is registered in order: the accepted word is captured, then the row of cells shifts
// and the read lanes fold into group registers, then the groups fold into the output register.
// in_stall holds after acceptance until the result is loaded, so no new word is taken before then.
// Reset empties the list (length zero); the cell contents are undefined until written.
// A result waiting under out_stall does not block acceptance of the next word; that word
// then waits in the gather step until the output register frees.

module positional_list_engine_unit #(
	parameter int CAPACITY   = plc_pkg::CAPACITY_DEF,
	parameter int ITEM_WIDTH = plc_pkg::ITEM_WIDTH_DEF,
	parameter int LEN_W      = $clog2(CAPACITY + 1)
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output logic                                in_stall,
	input  wire logic [1:0]                     opcode,
	input  wire logic [LEN_W-1:0]               position,
	input  wire logic [plc_pkg::PORT_ITEM_W-1:0] item_in,
	output logic                                out_valid,
	input  wire logic                           out_stall,
	output logic                                ok,
	output logic      [plc_pkg::PORT_ITEM_W-1:0] item_out,
	output logic      [LEN_W-1:0]               length,
	output logic                                empty_res
);
	import plc_pkg::*;

	localparam int GRP  = 16;
	localparam int NGRP = (CAPACITY + GRP - 1) / GRP;
	localparam logic [LEN_W-1:0] CAP_L = LEN_W'(CAPACITY);

	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_EXEC   = 3'b010,
		ST_GATHER = 3'b100
	} state_t;

	state_t                 state_q;
	logic [LEN_W-1:0]       count_q;
	logic                   out_valid_q;

	logic [1:0]             op_s1;
	logic [LEN_W-1:0]       pos_s1;
	logic [ITEM_WIDTH-1:0]  item_s1;
	logic [ITEM_WIDTH-1:0]  item_w;

	logic                   res_ok_s2;
	logic [LEN_W-1:0]       res_len_s2;
	logic [ITEM_WIDTH-1:0]  grp_s2 [NGRP];
	logic [ITEM_WIDTH-1:0]  grp_d  [NGRP];

	logic                   ok_q;
	logic [PORT_ITEM_W-1:0] item_out_q;
	logic [LEN_W-1:0]       length_q;
	logic                   empty_q;

	logic                   accept;
	logic                   exec;
	logic                   is_wr;
	logic [LEN_W-1:0]       at;
	logic                   ok_exec;
	logic [LEN_W-1:0]       count_next;
	cell_ctrl_t             ctrl;
	logic                   out_load;
	logic [ITEM_WIDTH-1:0]  gathered;
	logic [PORT_ITEM_W-1:0] gathered_port;

	logic [ITEM_WIDTH-1:0]  cell_item [CAPACITY];
	logic [ITEM_WIDTH-1:0]  cell_rd   [CAPACITY];

	// item width adjustment between port and storage
	generate
		if (ITEM_WIDTH <= PORT_ITEM_W) begin : g_narrow
			assign item_w        = item_in[ITEM_WIDTH-1:0];
			assign gathered_port = PORT_ITEM_W'(gathered);
		end else begin : g_wide
			assign item_w        = ITEM_WIDTH'(item_in);
			assign gathered_port = gathered[PORT_ITEM_W-1:0];
		end
	endgenerate

	assign accept = in_valid && !in_stall;
	assign exec   = (state_q == ST_EXEC);

	// capture the request word
	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1   <= opcode;
			pos_s1  <= position;
			item_s1 <= item_w;
		end
	end

	// decide success against the current length
	always_comb begin
		is_wr      = (op_s1 == OP_APPEND) || (op_s1 == OP_INSERT);
		at         = (op_s1 == OP_APPEND) ? count_q : pos_s1;
		ok_exec    = 1'b0;
		count_next = count_q;
		unique case (op_s1)
			OP_APPEND, OP_INSERT: begin
				ok_exec = (count_q < CAP_L) && (at <= count_q);
				if (ok_exec) begin
					count_next = count_q + 1'b1;
				end
			end
			OP_REMOVE: begin
				ok_exec = (pos_s1 < count_q);
				if (ok_exec) begin
					count_next = count_q - 1'b1;
				end
			end
			OP_READ: begin
				ok_exec = (pos_s1 < count_q);
			end
			default: begin
				ok_exec = 1'b0;
			end
		endcase
		ctrl.ins = exec && ok_exec && is_wr;
		ctrl.rem = exec && ok_exec && (op_s1 == OP_REMOVE);
		ctrl.rd  = exec && ok_exec && (op_s1 == OP_READ);
	end

	// the row of cells
	generate
		for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
			logic [ITEM_WIDTH-1:0] left_w;
			logic [ITEM_WIDTH-1:0] right_w;
			if (i == 0) begin : g_first
				assign left_w = '0;
			end else begin : g_mid_l
				assign left_w = cell_item[i-1];
			end
			if (i == CAPACITY - 1) begin : g_last
				assign right_w = '0;
			end else begin : g_mid_r
				assign right_w = cell_item[i+1];
			end
			plc_cell #(
				.ITEM_WIDTH(ITEM_WIDTH),
				.LEN_W     (LEN_W),
				.IDX       (i)
			) u_cell (
				.clk       (clk),
				.ctrl      (ctrl),
				.at        (at),
				.new_item  (item_s1),
				.left_item (left_w),
				.right_item(right_w),
				.item      (cell_item[i]),
				.rd_item   (cell_rd[i])
			);
		end
	endgenerate

	// first level of the read tree: one group of lanes each
	always_comb begin
		for (int g = 0; g < NGRP; g++) begin
			grp_d[g] = '0;
			for (int j = 0; j < GRP; j++) begin
				if (g * GRP + j < CAPACITY) begin
					grp_d[g] = grp_d[g] | cell_rd[g * GRP + j];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (exec) begin
			grp_s2     <= grp_d;
			res_ok_s2  <= ok_exec;
			res_len_s2 <= count_next;
		end
	end

	// second level of the read tree
	always_comb begin
		gathered = '0;
		for (int g = 0; g < NGRP; g++) begin
			gathered = gathered | grp_s2[g];
		end
	end

	assign out_load = (state_q == ST_GATHER) && (!out_valid_q || !out_stall);

	// output register
	always_ff @(posedge clk) begin
		if (out_load) begin
			ok_q       <= res_ok_s2;
			item_out_q <= gathered_port;
			length_q   <= res_len_s2;
			empty_q    <= (res_len_s2 == '0);
		end
	end

	// sequencing, length and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					count_q <= count_next;
					state_q <= ST_GATHER;
				end
				ST_GATHER: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign ok        = ok_q;
	assign item_out  = item_out_q;
	assign length    = length_q;
	assign empty_res = empty_q;

	// checks
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CAP_L)
		else $error("list length above capacity");

	a_state_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q))
		else $error("sequencer state not one-hot");

	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ST_EXEC))
		else $error("accepted word did not reach the cell row");

	a_remove_len: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.rem |=> (count_q == $past(count_q) - 1'b1))
		else $error("successful remove did not shorten the list");

	a_ins_cap: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.ins |-> (count_q < CAP_L))
		else $error("insert into a full list");

endmodule

`default_nettype wire
